// ===== rtl/b128_pkg.sv =====
// ----------------------------------------------------------------------------
// b128_pkg
// Shared types, constants and character mapping functions of the base-128
// codec.
// ----------------------------------------------------------------------------
package b128_pkg;

  localparam int GRP_IN  = 7;   // bytes per encoded group
  localparam int GRP_OUT = 8;   // characters per encoded group

  localparam logic [7:0] PAD_CHAR = 8'h21;  // '!'
  localparam logic [7:0] MAP_BAD  = 8'hFF;
  localparam logic [7:0] MAP_PAD  = 8'hFE;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Configuration register indexes
  localparam logic [0:0] REG_DIRECTION = 1'b0;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } b128_state_t;

  typedef enum logic [1:0] {
    K_ENC,
    K_DEC,
    K_ERR
  } b128_kind_t;

  typedef struct packed {
    logic       accept;
    logic       load;
    logic       last;
    logic [2:0] idx;
  } b128_cmd_t;

  typedef struct packed {
    logic [2:0] res_cnt;
    logic       out_free;
  } b128_sts_t;

  function automatic logic [7:0] enc_char(input logic [6:0] idx);
    logic [7:0] v;
    v = {1'b0, idx};
    if (v < 8'd57) begin
      return v + 8'h23;
    end else if (v < 8'd91) begin
      return v + 8'h24;
    end else begin
      return v + 8'd69;
    end
  endfunction

  function automatic logic [7:0] dec_char(input logic [7:0] c);
    logic [7:0] r;
    r = MAP_BAD;
    if (c == 8'h09) r = 8'd187;
    else if (c == 8'h0B) r = 8'd188;
    else if (c == 8'h1B) r = 8'd189;
    else if (c == 8'h1C) r = 8'd190;
    else if (c == 8'h20) r = 8'd191;
    else if (c == PAD_CHAR) r = MAP_PAD;
    else if (c >= 8'h23 && c <= 8'h5B) r = c - 8'h23;
    else if (c >= 8'h5D && c <= 8'h7E) r = c - 8'h24;
    else if (c >= 8'hA0) r = c - 8'd69;
    return r;
  endfunction

endpackage

// ===== rtl/b128_ctrl.sv =====
// ----------------------------------------------------------------------------
// b128_ctrl
// Controller: takes requests in, then steps the datapath through the results
// of each request, one per cycle into the output register while it is free.
// ----------------------------------------------------------------------------
module b128_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  b128_pkg::b128_sts_t sts,
  output b128_pkg::b128_cmd_t cmd
);
  import b128_pkg::*;

  b128_state_t state_r, state_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [2:0]  cnt_r, cnt_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept && (sts.res_cnt != 3'd0)) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.load && cmd.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = 1'b0;
    cmd.accept = 1'b0;
    cmd.load   = 1'b0;
    cmd.last   = (idx_r == (cnt_r - 3'd1));
    cmd.idx    = idx_r;
    case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_EMIT: begin
        cmd.load = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    if (cmd.accept) begin
      idx_nxt = 3'd0;
      cnt_nxt = sts.res_cnt;
    end else if (cmd.load) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= 3'd0;
      cnt_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> cnt_r != 3'd0)
    else $error("emitting with zero result count");

  a_emit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> idx_r < cnt_r)
    else $error("result index ran past count");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && cmd.load && cmd.last) |=> state_r == ST_IDLE)
    else $error("last result did not return to idle");

endmodule

// ===== rtl/b128_dp.sv =====
// ----------------------------------------------------------------------------
// b128_dp
// Datapath: group state, decode buffer, result latches and output register.
// ----------------------------------------------------------------------------
module b128_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                direction,
  input  logic                cfg_clr,
  input  logic [7:0]          in_data,
  input  logic                in_last,
  input  b128_pkg::b128_cmd_t cmd,
  output b128_pkg::b128_sts_t sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_data,
  output logic                out_last,
  output logic                out_err
);
  import b128_pkg::*;

  // group state
  logic [2:0] gc_r;
  logic [6:0] top_bits_r;
  logic       discard_r;
  logic       pad_seen_r;   // '!' seen among the data characters
  logic       bad_r;        // illegal character before any pad
  logic [2:0] dcnt_r;       // data characters before the pad
  logic [7:0] buf_r [GRP_IN];

  // latched per request
  b128_kind_t kind_r;
  logic [7:0] enc0_r;
  logic [7:0] enc_tb_r;
  logic       pad_r;
  logic [6:0] dtb_r;

  // output register
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_last_r;
  logic       out_err_r;

  logic [6:0] tb_new;
  logic       gend_e, gend_d;
  logic [7:0] dval;
  logic [7:0] sel_data;
  logic       tb_hit;

  assign tb_new = top_bits_r | (in_data[7] ? (7'h40 >> gc_r) : 7'h00);
  assign gend_e = (gc_r == 3'(GRP_IN - 1)) || in_last;
  assign gend_d = (gc_r == 3'(GRP_OUT - 1)) || in_last;
  assign dval   = dec_char(in_data);

  always_comb begin
    sts.out_free = !out_valid_r || out_ready;
    sts.res_cnt  = 3'd0;
    if (!direction) begin
      if (!gend_e) sts.res_cnt = 3'd1;
      else if (gc_r == 3'(GRP_IN - 1)) sts.res_cnt = 3'd2;
      else sts.res_cnt = 3'd3;
    end else if (!discard_r && gend_d) begin
      sts.res_cnt = bad_r ? 3'd1 : dcnt_r;
    end
  end

  // group state and decode buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gc_r       <= 3'd0;
      top_bits_r <= 7'd0;
      discard_r  <= 1'b0;
      pad_seen_r <= 1'b0;
      bad_r      <= 1'b0;
      dcnt_r     <= 3'd0;
    end else if (cfg_clr) begin
      gc_r       <= 3'd0;
      top_bits_r <= 7'd0;
      discard_r  <= 1'b0;
      pad_seen_r <= 1'b0;
      bad_r      <= 1'b0;
      dcnt_r     <= 3'd0;
    end else if (cmd.accept) begin
      if (!direction) begin
        gc_r       <= gend_e ? 3'd0 : gc_r + 3'd1;
        top_bits_r <= gend_e ? 7'd0 : tb_new;
      end else if (discard_r) begin
        if (in_last) begin
          discard_r  <= 1'b0;
          gc_r       <= 3'd0;
          pad_seen_r <= 1'b0;
          bad_r      <= 1'b0;
          dcnt_r     <= 3'd0;
        end
      end else if (gend_d) begin
        // error drops the rest of the message unless this ends it
        discard_r  <= bad_r && !in_last;
        gc_r       <= 3'd0;
        pad_seen_r <= 1'b0;
        bad_r      <= 1'b0;
        dcnt_r     <= 3'd0;
      end else begin
        gc_r <= gc_r + 3'd1;
        if (!pad_seen_r && !bad_r) begin
          if (in_data == PAD_CHAR) pad_seen_r <= 1'b1;
          else if (dval == MAP_BAD) bad_r <= 1'b1;
          else dcnt_r <= dcnt_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && direction && !discard_r && !gend_d) begin
      buf_r[gc_r] <= dval;
    end
  end

  // per-request result latches
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= K_ENC;
    end else if (cmd.accept) begin
      if (!direction) kind_r <= K_ENC;
      else if (bad_r) kind_r <= K_ERR;
      else kind_r <= K_DEC;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      enc0_r   <= enc_char(in_data[6:0]);
      enc_tb_r <= enc_char(tb_new);
      pad_r    <= (gc_r != 3'(GRP_IN - 1));
      dtb_r    <= dval[6:0];
    end
  end

  // result select
  assign tb_hit = dtb_r[3'd6 - cmd.idx];

  always_comb begin
    sel_data = 8'd0;
    case (kind_r)
      K_ENC: begin
        if (cmd.idx == 3'd0) sel_data = enc0_r;
        else if (cmd.idx == 3'd1 && pad_r) sel_data = PAD_CHAR;
        else sel_data = enc_tb_r;
      end
      K_DEC: begin
        sel_data = buf_r[cmd.idx] | {tb_hit, 7'd0};
      end
      K_ERR: begin
        sel_data = 8'd0;
      end
      default: sel_data = 8'd0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= sel_data;
      out_last_r <= cmd.last;
      out_err_r  <= (kind_r == K_ERR);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;
  assign out_err   = out_err_r;

  a_enc_gc: assert property (@(posedge clk) disable iff (!rst_n)
    !direction |-> gc_r < 3'(GRP_IN))
    else $error("encode group count out of range");

  a_dec_tb: assert property (@(posedge clk) disable iff (!rst_n)
    direction |-> top_bits_r == 7'd0)
    else $error("top bits gathered while decoding");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> out_last_r)
    else $error("error result not marked last");

endmodule

// ===== rtl/base128_codec.sv =====
// ----------------------------------------------------------------------------
// base128_codec
// Base-128 byte stream encoder/decoder with an APB-style control register.
// ----------------------------------------------------------------------------
// Register 0 (byte address 0), bit 0 = direction: 0 encodes bytes into
// characters of a 128-entry alphabet, 1 decodes characters back to bytes.
// Writing it restarts the group state; write it only while the block is idle.
// Encoding: every byte gives its character at once; every seventh byte, or a
// byte with tlast set, closes the group with an optional '!' pad and one
// character carrying the gathered top bits. Decoding: characters are held
// until the eighth, or one with tlast set; the group then yields one byte per
// character before the pad or the top-bits character. An illegal character
// ahead of the pad and the top-bits character gives a single result with
// tuser (error) set at the group's end and drops the rest of the message up
// to tlast. out_tlast marks the last result of a request. After taking a
// request the block emits its results (encode 1 to 3, decode 0 to 7) before
// it takes the next one, since all results leave one at a time through a
// single output register. Back-pressure on the output stalls the results.
// ----------------------------------------------------------------------------
module base128_codec (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] data_byte
  input  logic                        in_tlast,   // message_end
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [7:0] out_byte
  output logic                        out_tlast,  // run_last
  output logic                        out_tuser,  // [0] error
  // control registers
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [b128_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [b128_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [b128_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import b128_pkg::*;

  b128_cmd_t cmd;
  b128_sts_t sts;

  logic direction_r;
  logic cfg_wr;
  logic cfg_hit;

  // one word of registers: bit 2 picks the word, byte lanes ignored
  assign cfg_hit    = (cfg_paddr[2] == REG_DIRECTION);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? {{(CFG_DW-1){1'b0}}, direction_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
    end else if (cfg_wr) begin
      direction_r <= cfg_pwdata[0];
    end
  end

  b128_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  b128_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .direction (direction_r),
    .cfg_clr   (cfg_wr),
    .in_data   (in_tdata),
    .in_last   (in_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .out_err   (out_tuser)
  );

endmodule
